>>> hdl/cspoll_pkg.sv
// ----------------------------------------------------------------------------
// cspoll_pkg : shared types, codes and frame tables for the sensor poller
// Command, phase and result codes, the queued job type and the transmit
// byte table used by the front and back halves.
// ----------------------------------------------------------------------------
package cspoll_pkg;

  // payload clip limit and queue depth defaults
  localparam int PAYLOAD_LIMIT_DEF = 15;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // payload byte counter width, fixed by the largest clip limit
  localparam int COUNT_W = 4;

  // input modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;
  localparam logic [1:0] MODE_CAL  = 2'd3;

  // pending command codes, also used as frame codes in a job
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_SERIAL    = 3'd1;
  localparam logic [2:0] CMD_VERSION   = 3'd2;
  localparam logic [2:0] CMD_PPM       = 3'd3;
  localparam logic [2:0] CMD_STATUS    = 3'd4;
  localparam logic [2:0] CMD_ELEVATION = 3'd5;
  localparam logic [2:0] CMD_TARGET    = 3'd6;
  localparam logic [2:0] CMD_CALIBRATE = 3'd7;

  // receive phases
  localparam logic [2:0] PH_DISCARD = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // result kinds
  localparam logic [3:0] KIND_TX          = 4'd0;
  localparam logic [3:0] KIND_CO2         = 4'd1;
  localparam logic [3:0] KIND_STATUS      = 4'd2;
  localparam logic [3:0] KIND_ELEVATION   = 4'd3;
  localparam logic [3:0] KIND_CAL_OK      = 4'd4;
  localparam logic [3:0] KIND_CAL_REJECT  = 4'd5;
  localparam logic [3:0] KIND_REPLY_TMO   = 4'd6;
  localparam logic [3:0] KIND_BAD_HEADER  = 4'd7;
  localparam logic [3:0] KIND_PAYLOAD_TMO = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_REPLY_TMO   = 2'd0;
  localparam logic [1:0] REG_SLOW_TMO    = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_TMO = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] REPLY_TMO_RST   = 16'd1000;
  localparam logic [15:0] SLOW_TMO_RST    = 16'd5000;
  localparam logic [15:0] PAYLOAD_TMO_RST = 16'd50;

  // frame bytes
  localparam logic [7:0] HDR_MAGIC    = 8'hFF;
  localparam logic [7:0] HDR_ADDR     = 8'hFA;
  localparam logic [7:0] TX_HOST      = 8'hFE;
  localparam logic [7:0] TX_LEN_ONE   = 8'h01;
  localparam logic [7:0] TX_LEN_TWO   = 8'h02;
  localparam logic [7:0] TX_LEN_WRITE = 8'h04;
  localparam logic [7:0] OP_READ      = 8'h02;
  localparam logic [7:0] OP_UPDATE    = 8'h03;
  localparam logic [7:0] OP_STATUS    = 8'hB6;
  localparam logic [7:0] OP_CALIBRATE = 8'h9B;
  localparam logic [7:0] VAR_SERIAL   = 8'h01;
  localparam logic [7:0] VAR_VERSION  = 8'h0D;
  localparam logic [7:0] VAR_PPM      = 8'h03;
  localparam logic [7:0] VAR_ELEV     = 8'h0F;
  localparam logic [7:0] VAR_TARGET   = 8'h11;

  // rotation slots after serial and version
  localparam logic [2:0] ROT_STATUS = 3'd4;
  localparam logic [2:0] ROT_ELEV   = 3'd5;
  localparam logic [2:0] ROT_LAST   = 3'd5;

  // one queued unit of output work: a command frame or a single report
  typedef struct packed {
    logic [2:0]  frame;    // command code, CMD_NONE for a single report
    logic [3:0]  kind;
    logic [15:0] value;    // target for a target write frame
    logic        warning;
  } cspoll_job_t;

  function automatic logic [2:0] frame_len(input logic [2:0] frame);
    logic [2:0] n;
    begin
      case (frame)
        CMD_SERIAL, CMD_VERSION, CMD_PPM, CMD_ELEVATION: n = 3'd5;
        CMD_STATUS, CMD_CALIBRATE:                       n = 3'd4;
        CMD_TARGET:                                      n = 3'd7;
        default:                                         n = 3'd1;
      endcase
      return n;
    end
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] frame,
                                            input logic [2:0] idx,
                                            input logic [15:0] value);
    logic [7:0] b;
    begin
      b = 8'h00;
      if (idx == 3'd0) begin
        b = HDR_MAGIC;
      end else if (idx == 3'd1) begin
        b = TX_HOST;
      end else begin
        case (frame)
          CMD_STATUS: begin
            b = (idx == 3'd2) ? TX_LEN_ONE : OP_STATUS;
          end
          CMD_CALIBRATE: begin
            b = (idx == 3'd2) ? TX_LEN_ONE : OP_CALIBRATE;
          end
          CMD_TARGET: begin
            case (idx)
              3'd2:    b = TX_LEN_WRITE;
              3'd3:    b = OP_UPDATE;
              3'd4:    b = VAR_TARGET;
              3'd5:    b = value[15:8];
              default: b = value[7:0];
            endcase
          end
          CMD_SERIAL, CMD_VERSION, CMD_PPM, CMD_ELEVATION: begin
            case (idx)
              3'd2:    b = TX_LEN_TWO;
              3'd3:    b = OP_READ;
              default: begin
                case (frame)
                  CMD_SERIAL:  b = VAR_SERIAL;
                  CMD_VERSION: b = VAR_VERSION;
                  CMD_PPM:     b = VAR_PPM;
                  default:     b = VAR_ELEV;
                endcase
              end
            endcase
          end
          default: b = 8'h00;
        endcase
      end
      return b;
    end
  endfunction

endpackage

>>> hdl/cspoll_front.sv
// ----------------------------------------------------------------------------
// cspoll_front : event decoder and protocol state
// Takes one event per cycle while accept is high, updates the command, receive and timer state
// and hands a job describing the resulting output to the queue.
// ----------------------------------------------------------------------------
module cspoll_front #(
  parameter int PAYLOAD_LIMIT = cspoll_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [1:0]              mode,
  input  logic [7:0]              rx_byte,
  input  logic [15:0]             cal_target,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  output logic                    push,
  output cspoll_pkg::cspoll_job_t job
);

  localparam logic [7:0] LIMIT8 = 8'(PAYLOAD_LIMIT);

  logic [15:0] reply_tmo, slow_tmo, payload_tmo;

  logic [2:0]  pending, pending_next;
  logic [15:0] age, age_next;
  logic [2:0]  phase, phase_next;
  logic        mismatch, mismatch_next;
  logic [7:0]  reply_len, reply_len_next;
  logic [cspoll_pkg::COUNT_W-1:0] count, count_next, want;
  logic [7:0]  first, first_next;
  logic [7:0]  second, second_next;
  logic [15:0] pay_wait, pay_wait_next;
  logic [7:0]  poll_idx, poll_idx_next;
  logic [2:0]  rot, rot_next;
  logic        warning, warning_next;

  logic [15:0] window, age_inc, wait_inc, start_value;
  logic        do_fail, do_finish, do_start;
  logic [3:0]  fail_kind;
  logic [7:0]  fin_f, fin_s, fin_len;
  logic [2:0]  start_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_tmo   <= cspoll_pkg::REPLY_TMO_RST;
      slow_tmo    <= cspoll_pkg::SLOW_TMO_RST;
      payload_tmo <= cspoll_pkg::PAYLOAD_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cspoll_pkg::REG_REPLY_TMO:   reply_tmo   <= cfg_wdata;
        cspoll_pkg::REG_SLOW_TMO:    slow_tmo    <= cfg_wdata;
        cspoll_pkg::REG_PAYLOAD_TMO: payload_tmo <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pending_next   = pending;
    age_next       = age;
    phase_next     = phase;
    mismatch_next  = mismatch;
    reply_len_next = reply_len;
    count_next     = count;
    first_next     = first;
    second_next    = second;
    pay_wait_next  = pay_wait;
    poll_idx_next  = poll_idx;
    rot_next       = rot;
    warning_next   = warning;

    push        = 1'b0;
    job         = '0;
    do_fail     = 1'b0;
    fail_kind   = cspoll_pkg::KIND_TX;
    do_finish   = 1'b0;
    fin_f       = first;
    fin_s       = second;
    fin_len     = reply_len;
    do_start    = 1'b0;
    start_cmd   = cspoll_pkg::CMD_NONE;
    start_value = 16'd0;

    window = (pending == cspoll_pkg::CMD_TARGET || pending == cspoll_pkg::CMD_CALIBRATE)
             ? slow_tmo : reply_tmo;
    age_inc  = (age == 16'hFFFF) ? age : age + 16'd1;
    wait_inc = (pay_wait == 16'hFFFF) ? pay_wait : pay_wait + 16'd1;
    want     = (reply_len > LIMIT8) ? LIMIT8[cspoll_pkg::COUNT_W-1:0]
                                    : reply_len[cspoll_pkg::COUNT_W-1:0];

    if (accept) begin
      case (mode)
        cspoll_pkg::MODE_BYTE: begin
          case (phase)
            cspoll_pkg::PH_MAGIC: begin
              mismatch_next = (rx_byte != cspoll_pkg::HDR_MAGIC);
              phase_next    = cspoll_pkg::PH_ADDR;
            end
            cspoll_pkg::PH_ADDR: begin
              if (rx_byte != cspoll_pkg::HDR_ADDR) mismatch_next = 1'b1;
              phase_next = cspoll_pkg::PH_LEN;
            end
            cspoll_pkg::PH_LEN: begin
              reply_len_next = rx_byte;
              if (mismatch) begin
                do_fail   = 1'b1;
                fail_kind = cspoll_pkg::KIND_BAD_HEADER;
              end else begin
                warning_next  = 1'b0;
                first_next    = 8'd0;
                second_next   = 8'd0;
                count_next    = '0;
                pay_wait_next = 16'd0;
                if (rx_byte == 8'd0) begin
                  do_finish = 1'b1;
                  fin_f     = 8'd0;
                  fin_s     = 8'd0;
                  fin_len   = 8'd0;
                end else begin
                  phase_next = cspoll_pkg::PH_PAYLOAD;
                end
              end
            end
            cspoll_pkg::PH_PAYLOAD: begin
              if (count == '0) first_next = rx_byte;
              else if (count == cspoll_pkg::COUNT_W'(1)) second_next = rx_byte;
              count_next = count + cspoll_pkg::COUNT_W'(1);
              if (count_next >= want) begin
                do_finish = 1'b1;
                fin_f     = first_next;
                fin_s     = second_next;
              end
            end
            default: ;
          endcase
        end
        cspoll_pkg::MODE_TICK: begin
          if (phase == cspoll_pkg::PH_PAYLOAD) begin
            age_next      = age_inc;
            pay_wait_next = wait_inc;
            if (wait_inc > payload_tmo) begin
              do_fail   = 1'b1;
              fail_kind = cspoll_pkg::KIND_PAYLOAD_TMO;
            end
          end else if (pending != cspoll_pkg::CMD_NONE) begin
            age_next = age_inc;
            if (age_inc >= window) begin
              do_fail   = 1'b1;
              fail_kind = cspoll_pkg::KIND_REPLY_TMO;
            end
          end
        end
        cspoll_pkg::MODE_POLL: begin
          if (phase != cspoll_pkg::PH_PAYLOAD &&
              !(pending != cspoll_pkg::CMD_NONE && age < window)) begin
            do_start = 1'b1;
            if (poll_idx == 8'd0) start_cmd = cspoll_pkg::CMD_SERIAL;
            else if (poll_idx == 8'd1) start_cmd = cspoll_pkg::CMD_VERSION;
            else if (rot == cspoll_pkg::ROT_STATUS) start_cmd = cspoll_pkg::CMD_STATUS;
            else if (rot == cspoll_pkg::ROT_ELEV) start_cmd = cspoll_pkg::CMD_ELEVATION;
            else start_cmd = cspoll_pkg::CMD_PPM;
            // rot tracks (poll_idx - 2) mod 6 and freezes with the saturated index
            if (poll_idx >= 8'd2 && poll_idx != 8'hFF) begin
              rot_next = (rot == cspoll_pkg::ROT_LAST) ? 3'd0 : rot + 3'd1;
            end
            if (poll_idx != 8'hFF) poll_idx_next = poll_idx + 8'd1;
          end
        end
        default: begin
          do_start    = 1'b1;
          start_cmd   = cspoll_pkg::CMD_TARGET;
          start_value = cal_target;
        end
      endcase

      if (do_finish) begin
        case (pending)
          cspoll_pkg::CMD_PPM: begin
            push       = 1'b1;
            job.kind   = cspoll_pkg::KIND_CO2;
            job.value  = {fin_f, fin_s};
          end
          cspoll_pkg::CMD_STATUS: begin
            push       = 1'b1;
            job.kind   = cspoll_pkg::KIND_STATUS;
            job.value  = {8'd0, fin_f};
          end
          cspoll_pkg::CMD_ELEVATION: begin
            push       = 1'b1;
            job.kind   = cspoll_pkg::KIND_ELEVATION;
            job.value  = {fin_f, fin_s};
          end
          cspoll_pkg::CMD_CALIBRATE: begin
            push = 1'b1;
            if (fin_len == 8'd0) begin
              job.kind = cspoll_pkg::KIND_CAL_OK;
            end else begin
              job.kind  = cspoll_pkg::KIND_CAL_REJECT;
              job.value = {8'd0, fin_f};
            end
          end
          cspoll_pkg::CMD_TARGET: begin
            // write acknowledged: chain straight into the calibrate command
            do_start  = 1'b1;
            start_cmd = cspoll_pkg::CMD_CALIBRATE;
          end
          default: ;
        endcase
        if (pending != cspoll_pkg::CMD_TARGET) begin
          pending_next = cspoll_pkg::CMD_NONE;
          age_next     = 16'd0;
          phase_next   = cspoll_pkg::PH_DISCARD;
        end
      end

      if (do_fail) begin
        push         = 1'b1;
        job.kind     = fail_kind;
        warning_next = 1'b1;
        pending_next = cspoll_pkg::CMD_NONE;
        age_next     = 16'd0;
        phase_next   = cspoll_pkg::PH_DISCARD;
      end

      if (do_start) begin
        pending_next   = start_cmd;
        age_next       = 16'd0;
        phase_next     = cspoll_pkg::PH_MAGIC;
        mismatch_next  = 1'b0;
        reply_len_next = 8'd0;
        count_next     = '0;
        first_next     = 8'd0;
        second_next    = 8'd0;
        pay_wait_next  = 16'd0;
        push           = 1'b1;
        job.frame      = start_cmd;
        job.kind       = cspoll_pkg::KIND_TX;
        job.value      = start_value;
      end
    end

    job.warning = warning_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= cspoll_pkg::CMD_NONE;
      age       <= 16'd0;
      phase     <= cspoll_pkg::PH_DISCARD;
      mismatch  <= 1'b0;
      reply_len <= 8'd0;
      count     <= '0;
      first     <= 8'd0;
      second    <= 8'd0;
      pay_wait  <= 16'd0;
      poll_idx  <= 8'd0;
      rot       <= 3'd0;
      warning   <= 1'b0;
    end else begin
      pending   <= pending_next;
      age       <= age_next;
      phase     <= phase_next;
      mismatch  <= mismatch_next;
      reply_len <= reply_len_next;
      count     <= count_next;
      first     <= first_next;
      second    <= second_next;
      pay_wait  <= pay_wait_next;
      poll_idx  <= poll_idx_next;
      rot       <= rot_next;
      warning   <= warning_next;
    end
  end

  a_phase_has_cmd: assert property (@(posedge clk) disable iff (rst)
    (phase != cspoll_pkg::PH_DISCARD) |-> (pending != cspoll_pkg::CMD_NONE))
    else $error("receive phase active with no command pending");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    rot <= cspoll_pkg::ROT_LAST)
    else $error("poll rotation slot out of range");

endmodule

>>> hdl/cspoll_queue.sv
// ----------------------------------------------------------------------------
// cspoll_queue : job queue between front and back
// Small register fifo so the decoder and the output sequencer stall apart.
// ----------------------------------------------------------------------------
module cspoll_queue #(
  parameter int DEPTH = cspoll_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  cspoll_pkg::cspoll_job_t push_job,
  output logic                    full,
  input  logic                    pop,
  output cspoll_pkg::cspoll_job_t head,
  output logic                    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cspoll_pkg::cspoll_job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("job pushed into a full queue");

endmodule

>>> hdl/cspoll_back.sv
// ----------------------------------------------------------------------------
// cspoll_back : output sequencer
// Expands each queued job into its result transactions, one per cycle
// while m_tready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
module cspoll_back (
  input  logic                    clk,
  input  logic                    rst,
  input  cspoll_pkg::cspoll_job_t head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,
  output logic [3:0]              m_tuser,
  output logic                    m_tlast
);

  logic [2:0] idx;
  logic [2:0] len;
  logic       load, is_last;
  logic [7:0] tx;

  assign len     = cspoll_pkg::frame_len(head.frame);
  assign is_last = (idx == len - 3'd1);
  assign load    = !empty && (!m_tvalid || m_tready);
  assign pop     = load && is_last;
  assign tx      = cspoll_pkg::frame_byte(head.frame, idx, head.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 3'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= is_last ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tlast <= is_last;
      if (head.frame == cspoll_pkg::CMD_NONE) begin
        m_tuser <= head.kind;
        m_tdata <= {7'd0, head.warning, head.value, 8'd0};
      end else begin
        m_tuser <= cspoll_pkg::KIND_TX;
        m_tdata <= {7'd0, head.warning, 16'd0, tx};
      end
    end
  end

  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0) |-> (m_tvalid && !m_tlast && !empty))
    else $error("frame position set without a frame in progress");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx < len))
    else $error("frame position past frame length");

  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != cspoll_pkg::KIND_TX) |-> m_tlast)
    else $error("report not marked as last of its event");

endmodule

>>> hdl/co2_sensor_uart_poller_top.sv
// ----------------------------------------------------------------------------
// co2_sensor_uart_poller_top : host side poller for a serial gas sensor
// Sends query and calibration frames, deframes and checks replies and
// reports readings, calibration outcome and timeouts.
//
//   channel   dir  payload
//   s_axis    in   tuser: mode[1:0]; tdata: rx_byte[7:0], cal_target[23:8]
//   m_axis    out  tuser: kind[3:0]; tdata: tx_byte[7:0], value[23:8],
//                  warning[24]; tlast: last result of the event
//   cfg       in   cfg_index 0 reply, 1 slow, 2 payload timeout (ms)
//
// an event is decoded in the cycle it is accepted; s_tready drops only
// while the job queue is full.
// each event yields 0 to 7 results, sent by the output sequencer one per
// cycle while m_tready is high.
// results pass through the job queue and then the registered output stage.
// stalls on m_tready fill the job queue and then back-pressure s_axis.
// rst is synchronous; configuration returns to 1000/5000/50 ms.
// ----------------------------------------------------------------------------
module co2_sensor_uart_poller_top #(
  parameter int PAYLOAD_LIMIT = cspoll_pkg::PAYLOAD_LIMIT_DEF,
  parameter int QUEUE_DEPTH   = cspoll_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte[7:0], cal_target[23:8]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // tx_byte[7:0], value[23:8], warning[24]
  output logic [3:0]  m_tuser,   // kind[3:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cspoll_pkg::cspoll_job_t push_job, head;
  logic push, full, pop, empty, accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  cspoll_front #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_tuser),
    .rx_byte    (s_tdata[7:0]),
    .cal_target (s_tdata[23:8]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .job        (push_job)
  );

  cspoll_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  cspoll_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the sensor uart poller
// Drives events (received bytes, ms ticks, polls, calibrate requests) into
// the slave stream, predicts every result with its own model of the poller
// and compares the master stream field by field. Covers the query rotation,
// reply deframing, header checks, payload clipping, all three timeouts, the
// calibration chain, register writes and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          REPLY_CLIP   = cspoll_pkg::PAYLOAD_LIMIT_DEF;
  localparam int          MAX_PRINTS   = 50;
  localparam int          RANDOM_EVENTS = 18;
  localparam int          ROTATION_POLLS = 12;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  tx;
    logic [15:0] value;
    logic        warning;
    logic        last;
  } poller_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = cspoll_pkg::MODE_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = cspoll_pkg::REG_REPLY_TMO;
  logic [15:0] cfg_wdata = '0;

  co2_sensor_uart_poller_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench bookkeeping
  poller_result_t due_results[$];
  poller_result_t step_results[$];
  int error_count     = 0;
  int events_sent     = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;
  int src_idle_pct    = 0;
  int snk_idle_pct    = 0;
  int hold_id         = 0;
  int hold_seen       = 0;
  int hold_left       = 0;

  // poller model state and its copy of the registers
  logic [15:0] win_reply, win_slow, win_payload;
  logic [2:0]  pend_cmd;
  logic [15:0] cmd_age;
  logic [2:0]  rx_phase;
  logic        hdr_bad;
  logic [7:0]  reply_len;
  logic [3:0]  pay_cnt;
  logic [7:0]  pay_b0, pay_b1;
  logic [15:0] pay_wait;
  logic [7:0]  poll_idx;
  logic        warn;

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, field,
               exp_val, got_val);
    error_count++;
  endtask

  // ---------------------------------------------------------------- model --
  function automatic void predictor_reset();
    win_reply   = cspoll_pkg::REPLY_TMO_RST;
    win_slow    = cspoll_pkg::SLOW_TMO_RST;
    win_payload = cspoll_pkg::PAYLOAD_TMO_RST;
    pend_cmd    = cspoll_pkg::CMD_NONE;
    cmd_age     = '0;
    rx_phase    = cspoll_pkg::PH_DISCARD;
    hdr_bad     = 1'b0;
    reply_len   = '0;
    pay_cnt     = '0;
    pay_b0      = '0;
    pay_b1      = '0;
    pay_wait    = '0;
    poll_idx    = '0;
    warn        = 1'b0;
  endfunction

  function automatic void note_result(input logic [3:0] kind, input logic [7:0] tx,
                                      input logic [15:0] val);
    poller_result_t r;
    r = '{kind: kind, tx: tx, value: val, warning: 1'b0, last: 1'b0};
    if (step_results.size() < 8) step_results.push_back(r);
  endfunction

  function automatic void open_command(input logic [2:0] cmd);
    pend_cmd  = cmd;
    cmd_age   = '0;
    rx_phase  = cspoll_pkg::PH_MAGIC;
    hdr_bad   = 1'b0;
    reply_len = '0;
    pay_cnt   = '0;
    pay_b0    = '0;
    pay_b1    = '0;
    pay_wait  = '0;
    note_result(cspoll_pkg::KIND_TX, cspoll_pkg::HDR_MAGIC, '0);
    note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_HOST, '0);
  endfunction

  function automatic void close_command();
    pend_cmd = cspoll_pkg::CMD_NONE;
    cmd_age  = '0;
    rx_phase = cspoll_pkg::PH_DISCARD;
  endfunction

  function automatic void raise_fault(input logic [3:0] kind);
    note_result(kind, '0, '0);
    warn = 1'b1;
    close_command();
  endfunction

  function automatic logic [15:0] reply_window(input logic [2:0] cmd);
    return (cmd == cspoll_pkg::CMD_TARGET || cmd == cspoll_pkg::CMD_CALIBRATE)
           ? win_slow : win_reply;
  endfunction

  function automatic void complete_reply();
    case (pend_cmd)
      cspoll_pkg::CMD_PPM:
        note_result(cspoll_pkg::KIND_CO2, '0, {pay_b0, pay_b1});
      cspoll_pkg::CMD_STATUS:
        note_result(cspoll_pkg::KIND_STATUS, '0, {8'h00, pay_b0});
      cspoll_pkg::CMD_ELEVATION:
        note_result(cspoll_pkg::KIND_ELEVATION, '0, {pay_b0, pay_b1});
      cspoll_pkg::CMD_TARGET: begin
        // target write acknowledged: chain straight into the calibrate command
        open_command(cspoll_pkg::CMD_CALIBRATE);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_ONE, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_CALIBRATE, '0);
        return;
      end
      cspoll_pkg::CMD_CALIBRATE: begin
        if (reply_len == 8'd0) note_result(cspoll_pkg::KIND_CAL_OK, '0, '0);
        else note_result(cspoll_pkg::KIND_CAL_REJECT, '0, {8'h00, pay_b0});
      end
      default: ;
    endcase
    close_command();
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [7:0] want;
    case (rx_phase)
      cspoll_pkg::PH_MAGIC: begin
        hdr_bad  = (b != cspoll_pkg::HDR_MAGIC);
        rx_phase = cspoll_pkg::PH_ADDR;
      end
      cspoll_pkg::PH_ADDR: begin
        if (b != cspoll_pkg::HDR_ADDR) hdr_bad = 1'b1;
        rx_phase = cspoll_pkg::PH_LEN;
      end
      cspoll_pkg::PH_LEN: begin
        reply_len = b;
        if (hdr_bad) begin
          raise_fault(cspoll_pkg::KIND_BAD_HEADER);
        end else begin
          warn     = 1'b0;
          pay_b0   = '0;
          pay_b1   = '0;
          pay_cnt  = '0;
          pay_wait = '0;
          if (b == 8'd0) complete_reply();
          else rx_phase = cspoll_pkg::PH_PAYLOAD;
        end
      end
      cspoll_pkg::PH_PAYLOAD: begin
        if (pay_cnt == 4'd0) pay_b0 = b;
        else if (pay_cnt == 4'd1) pay_b1 = b;
        pay_cnt = pay_cnt + 4'd1;
        want = (reply_len > REPLY_CLIP) ? 8'(REPLY_CLIP) : reply_len;
        if ({4'h0, pay_cnt} >= want) complete_reply();
      end
      default: ;
    endcase
  endfunction

  function automatic void age_one_ms();
    if (rx_phase == cspoll_pkg::PH_PAYLOAD) begin
      if (cmd_age != 16'hFFFF) cmd_age++;
      if (pay_wait != 16'hFFFF) pay_wait++;
      if (pay_wait > win_payload) raise_fault(cspoll_pkg::KIND_PAYLOAD_TMO);
      return;
    end
    if (pend_cmd == cspoll_pkg::CMD_NONE) return;
    if (cmd_age != 16'hFFFF) cmd_age++;
    if (cmd_age >= reply_window(pend_cmd)) raise_fault(cspoll_pkg::KIND_REPLY_TMO);
  endfunction

  function automatic void issue_poll();
    int slot;
    if (rx_phase == cspoll_pkg::PH_PAYLOAD) return;
    if (pend_cmd != cspoll_pkg::CMD_NONE && cmd_age < reply_window(pend_cmd)) return;
    if (poll_idx == 8'd0) begin
      open_command(cspoll_pkg::CMD_SERIAL);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_TWO, '0);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_READ, '0);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::VAR_SERIAL, '0);
    end else if (poll_idx == 8'd1) begin
      open_command(cspoll_pkg::CMD_VERSION);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_TWO, '0);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_READ, '0);
      note_result(cspoll_pkg::KIND_TX, cspoll_pkg::VAR_VERSION, '0);
    end else begin
      slot = (int'(poll_idx) - 2) % 6;
      if (slot == int'(cspoll_pkg::ROT_STATUS)) begin
        open_command(cspoll_pkg::CMD_STATUS);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_ONE, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_STATUS, '0);
      end else if (slot == int'(cspoll_pkg::ROT_ELEV)) begin
        open_command(cspoll_pkg::CMD_ELEVATION);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_TWO, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_READ, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::VAR_ELEV, '0);
      end else begin
        open_command(cspoll_pkg::CMD_PPM);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_TWO, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_READ, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::VAR_PPM, '0);
      end
    end
    if (poll_idx != 8'd255) poll_idx++;
  endfunction

  function automatic void predict_poller_results(input logic [1:0] mode,
                                                 input logic [7:0] rx,
                                                 input logic [15:0] tgt);
    poller_result_t r;
    step_results.delete();
    case (mode)
      cspoll_pkg::MODE_BYTE: absorb_byte(rx);
      cspoll_pkg::MODE_TICK: age_one_ms();
      cspoll_pkg::MODE_POLL: issue_poll();
      default: begin
        open_command(cspoll_pkg::CMD_TARGET);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::TX_LEN_WRITE, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::OP_UPDATE, '0);
        note_result(cspoll_pkg::KIND_TX, cspoll_pkg::VAR_TARGET, '0);
        note_result(cspoll_pkg::KIND_TX, tgt[15:8], '0);
        note_result(cspoll_pkg::KIND_TX, tgt[7:0], '0);
      end
    endcase
    foreach (step_results[k]) begin
      r         = step_results[k];
      r.warning = warn;
      r.last    = (k == step_results.size() - 1);
      due_results.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------- driving --
  task automatic send_event(input logic [1:0] mode, input logic [7:0] rx,
                            input logic [15:0] tgt);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {tgt, rx};
    do @(posedge clk); while (!s_tready);
    predict_poller_results(mode, rx, tgt);
    events_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(cspoll_pkg::MODE_BYTE, b, 16'($urandom));
  endtask

  task automatic send_tick();
    send_event(cspoll_pkg::MODE_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_poll();
    send_event(cspoll_pkg::MODE_POLL, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_cal(input logic [15:0] tgt);
    send_event(cspoll_pkg::MODE_CAL, 8'($urandom), tgt);
  endtask

  // good header, then n_bytes random payload bytes, ticks sprinkled in if asked
  task automatic send_reply(input logic [7:0] len, input int n_bytes, input bit with_ticks);
    send_byte(cspoll_pkg::HDR_MAGIC);
    send_byte(cspoll_pkg::HDR_ADDR);
    send_byte(len);
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(8'($urandom));
      if (with_ticks && $urandom_range(7) == 0) send_tick();
    end
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cspoll_pkg::REG_REPLY_TMO:   win_reply   = val;
      cspoll_pkg::REG_SLOW_TMO:    win_slow    = val;
      cspoll_pkg::REG_PAYLOAD_TMO: win_payload = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [7:0] pick_reply_len();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(3));
      6, 7:             return 8'($urandom_range(15, 4));
      8:                return 8'($urandom_range(255, 16));
      default:          return 8'd255;
    endcase
  endfunction

  // ----------------------------------------------------------------- tests --
  task automatic test_directed_exchanges();
    send_byte(8'h00);                 // nothing sent yet, byte is dropped
    send_byte(8'hFF);
    send_tick();                      // idle tick, no command pending
    send_poll();                      // serial query
    send_poll();                      // busy, ignored
    send_reply(8'd1, 1, 1'b0);        // serial reply swallowed
    send_poll();                      // version query
    send_reply(8'd0, 0, 1'b0);
    send_poll();                      // ppm query, answered with a broken header
    send_byte(8'h00);
    send_byte(cspoll_pkg::HDR_ADDR);
    send_byte(8'd5);
    send_poll();                      // ppm again, short payload
    send_reply(8'd1, 1, 1'b0);
    send_cal(16'hFFFF);
    send_cal(16'h0000);               // calibrate while busy drops the old one
    send_reply(8'd0, 0, 1'b0);        // target ack chains calibrate
    send_reply(8'd0, 0, 1'b0);        // calibrate accepted
  endtask

  task automatic test_timeouts_and_registers();
    wait_idle();
    write_register(cspoll_pkg::REG_REPLY_TMO, 16'd1);
    write_register(cspoll_pkg::REG_SLOW_TMO, 16'd2);
    write_register(cspoll_pkg::REG_PAYLOAD_TMO, 16'd1);
    send_poll();
    send_tick();                      // reply window runs out
    send_poll();
    send_reply(8'd2, 1, 1'b0);
    send_poll();                      // payload in progress, ignored
    send_tick();
    send_tick();                      // payload window runs out
    send_cal(16'($urandom));
    send_tick();
    send_tick();                      // slow window runs out
    send_cal(16'($urandom));
    send_reply(8'd0, 0, 1'b0);
    send_reply(8'd1, 1, 1'b0);        // calibrate refused
    wait_idle();
    write_register(cspoll_pkg::REG_REPLY_TMO, 16'hFFFF);
    send_poll();
    repeat (3) send_tick();
    wait_idle();
    // lowering the window leaves the pending query stale, so a poll replaces it
    write_register(cspoll_pkg::REG_REPLY_TMO, 16'd2);
    write_register(REG_UNUSED, 16'h0001);
    send_poll();
    wait_idle();
    write_register(cspoll_pkg::REG_SLOW_TMO, 16'hFFFF);
    write_register(cspoll_pkg::REG_PAYLOAD_TMO, 16'hFFFF);
    send_poll();
    send_reply(8'd3, 2, 1'b0);
    repeat (3) send_tick();
    send_cal(16'h8001);
  endtask

  task automatic test_random_traffic(input logic [15:0] reply_ms, input logic [15:0] slow_ms,
                                     input logic [15:0] payload_ms, input int n_events);
    int          first;
    int          n;
    logic [7:0]  len;
    wait_idle();
    write_register(cspoll_pkg::REG_REPLY_TMO, reply_ms);
    write_register(cspoll_pkg::REG_SLOW_TMO, slow_ms);
    write_register(cspoll_pkg::REG_PAYLOAD_TMO, payload_ms);
    first = events_sent;
    while (events_sent - first < n_events) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          send_poll();
          if ($urandom_range(3) == 0) send_tick();
          len = pick_reply_len();
          n   = (len > REPLY_CLIP) ? REPLY_CLIP : int'(len);
          if ($urandom_range(5) == 0) n = $urandom_range(n);
          send_reply(len, n, 1'b1);
        end
        9, 10, 11, 12: begin
          send_cal(16'($urandom));
          len = 8'($urandom_range(2));
          send_reply(len, int'(len), 1'b1);
          len = $urandom_range(1) ? 8'd0 : 8'($urandom_range(3, 1));
          send_reply(len, int'(len), 1'b1);
        end
        13, 14: begin
          // header whose magic and address bytes may each be corrupted
          send_byte($urandom_range(1) ? cspoll_pkg::HDR_MAGIC : 8'($urandom));
          send_byte($urandom_range(1) ? cspoll_pkg::HDR_ADDR : 8'($urandom));
          send_byte(8'($urandom));
        end
        15, 16:  repeat ($urandom_range(6, 1)) send_tick();
        17:      send_poll();
        default: send_event(2'($urandom), 8'($urandom), 16'($urandom));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_id <= hold_id + 1;
    repeat (8) begin
      send_cal(16'($urandom));
      send_poll();
      send_tick();
    end
    wait_idle();
  endtask

  // walks the query rotation through two full turns with a short reply window
  task automatic test_rotation_wrap();
    wait_idle();
    write_register(cspoll_pkg::REG_REPLY_TMO, 16'd1);
    repeat (ROTATION_POLLS) begin
      send_poll();
      if ($urandom_range(3) == 0) send_reply(8'd0, 0, 1'b0);
      else send_tick();
    end
  endtask

  // -------------------------------------------------------------- receiver --
  always @(posedge clk) begin
    if (hold_seen != hold_id) begin
      hold_seen <= hold_id;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    poller_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, m_tdata);
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (m_tuser !== want.kind) report_mismatch("kind", want.kind, m_tuser);
        if (m_tdata[7:0] !== want.tx) report_mismatch("tx_byte", want.tx, m_tdata[7:0]);
        if (m_tdata[23:8] !== want.value) report_mismatch("value", want.value, m_tdata[23:8]);
        if (m_tdata[24] !== want.warning)
          report_mismatch("warning", want.warning, m_tdata[24]);
        if (m_tdata[31:25] !== 7'd0) report_mismatch("tdata padding", 0, m_tdata[31:25]);
        if (m_tlast !== want.last) report_mismatch("last", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------- sequence --
  initial begin
    predictor_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 32;
    snk_idle_pct = 70;
    test_directed_exchanges();
    test_timeouts_and_registers();
    test_random_traffic(16'd4, 16'd6, 16'd3, RANDOM_EVENTS);

    src_idle_pct = 70;
    snk_idle_pct = 32;
    test_random_traffic(16'd1, 16'd1, 16'd1, RANDOM_EVENTS);
    test_backpressure();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_rotation_wrap();
    test_random_traffic(16'hFFFF, 16'hFFFF, 16'd5, RANDOM_EVENTS);
    wait_idle();

    $display("covered %0d events and %0d checked results across %0d register writes",
             events_sent, results_checked, reg_writes);
    $display("rotation, replies, header faults, timeouts, calibration and stalls exercised");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
